[rtl/nae_pkg.sv]
// Package with the opcodes, status codes, item types, fixed-point helpers and the tanh table builder of the evaluator.
package nae_pkg;

  localparam logic [2:0] OP_WRITE = 3'd0;
  localparam logic [2:0] OP_RESET = 3'd1;
  localparam logic [2:0] OP_ADD   = 3'd2;
  localparam logic [2:0] OP_PUSH  = 3'd3;
  localparam logic [2:0] OP_POP   = 3'd4;
  localparam logic [2:0] OP_EVAL  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVER  = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam logic [2:0] RG_FW  = 3'd0;
  localparam logic [2:0] RG_FB  = 3'd1;
  localparam logic [2:0] RG_L1W = 3'd2;
  localparam logic [2:0] RG_L1B = 3'd3;
  localparam logic [2:0] RG_L2W = 3'd4;
  localparam logic [2:0] RG_L2B = 3'd5;
  localparam logic [2:0] RG_OW  = 3'd6;
  localparam logic [2:0] RG_OB  = 3'd7;

  localparam int SUM_W = 48;

  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  region;
    logic [16:0] weight_index;
    logic [15:0] weight_value;
    logic [9:0]  feature_index;
    logic        side;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] score;
    logic [5:0]  stack_level;
  } out_item_t;

  function automatic logic signed [15:0] sat16(input logic signed [SUM_W-1:0] v);
    if (v > 48'sd32767) begin
      return 16'sh7fff;
    end else if (v < -48'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] clip_unit(input logic signed [15:0] v);
    if (v <= 16'sd0) begin
      return 16'sd0;
    end else if (v >= 16'sd4096) begin
      return 16'sd4096;
    end
    return v;
  endfunction

  // Arithmetic shift floors, which matches the round-half-up narrowing.
  function automatic logic signed [15:0] narrow(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] v;
    v = (s + 48'sd2048) >>> 12;
    return sat16(v);
  endfunction

  // Shift-and-subtract quotient, used only while the constant tanh table is built.
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q, r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Elaboration-time build of one tanh entry, as integer fixed-point math.
  function automatic logic [15:0] tanh_entry(input int i, input int entries);
    logic [63:0] one, t, t2, t3, t4, v, num, den;
    one = 64'd1 << 31;
    t = udiv64(64'(i) << 31, 64'd16 * 64'(entries));
    t2 = (t * t) >> 31;
    t3 = (t2 * t) >> 31;
    t4 = (t3 * t) >> 31;
    v = one - t + (t2 >> 1) - udiv64(t3, 64'd6) + udiv64(t4, 64'd24);
    for (int k = 0; k < 8; k++) begin
      v = (v * v) >> 31;
    end
    num = (one - v) * 64'd32768 + (one + v);
    den = 64'd2 * (one + v);
    return 16'(udiv64(num, den));
  endfunction

endpackage

[rtl/nae_if.sv]
// Valid/ready channel interface with a parameterized payload type.
interface nae_if #(parameter type PAYLOAD_T = logic) (input logic clk);
  logic     valid;
  logic     ready;
  PAYLOAD_T payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/nae_mem.sv]
// Generic single-port synchronous RAM with a registered read.
module nae_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[rtl/nnue_accumulator_evaluator.sv]
// Top level: weight memories, accumulator stack memory and the sequencer that runs each operation.
//
// Channel | Dir | Payload
// in      | in  | op, region, weight_index, weight_value, feature_index, side
// out     | out | status, score, stack_level
//
// One transaction at a time. Reset and add read, update and write each accumulator element in turn;
// push does one read and one write of the single stack RAM port per element.
// Evaluate does one multiply-accumulate a cycle.
// rst clears the stack pointer and the sequencer; memories are not cleared.
// The result is held in an output register until taken; in is not ready meanwhile.
module nnue_accumulator_evaluator #(
  parameter int ACCUM_DIM     = 128,
  parameter int HIDDEN_DIM    = 32,
  parameter int FEATURE_COUNT = 649,
  parameter int STACK_DEPTH   = 64,
  parameter int TANH_ENTRIES  = 1024
) (
  input logic clk,
  input logic rst,
  nae_if.sink   in,
  nae_if.source out
);
  import nae_pkg::*;

  localparam int FW_D = FEATURE_COUNT * ACCUM_DIM;
  localparam int L1_D = 2 * ACCUM_DIM * HIDDEN_DIM;
  localparam int L2_D = HIDDEN_DIM * HIDDEN_DIM;
  localparam int FW_A = $clog2(FW_D);
  localparam int FB_A = $clog2(ACCUM_DIM);
  localparam int L1_A = $clog2(L1_D);
  localparam int L2_A = $clog2(L2_D);
  localparam int H_A  = (HIDDEN_DIM > 1) ? $clog2(HIDDEN_DIM) : 1;
  localparam int SK_D = STACK_DEPTH * 2 * ACCUM_DIM;
  localparam int SK_A = $clog2(SK_D);
  localparam int SP_W = $clog2(STACK_DEPTH);
  localparam int I_W  = $clog2(2 * ACCUM_DIM) + 1;
  localparam int T_A  = $clog2(TANH_ENTRIES);

  localparam logic [3:0] S_IDLE = 4'd0, S_ACC = 4'd1, S_ACCW = 4'd2, S_PUSH = 4'd3,
                         S_PUSHW = 4'd4, S_L1 = 4'd5, S_L2 = 4'd6, S_L3 = 4'd7,
                         S_TANH = 4'd8, S_DONE = 4'd9, S_OUT = 4'd10, S_FIN = 4'd11;

  logic [3:0] state;
  logic [2:0] op;
  logic [2:0] region;
  logic [16:0] widx;
  logic signed [15:0] wval;
  logic [9:0] feat;
  logic side;
  logic [SP_W-1:0] sp;
  logic [1:0] status;
  logic signed [15:0] score;
  logic [I_W-1:0] ii;
  logic [H_A-1:0] jj;
  logic rd_valid;
  logic rd_last;
  logic signed [SUM_W-1:0] sum;
  logic signed [15:0] h1 [HIDDEN_DIM];
  logic signed [15:0] h2 [HIDDEN_DIM];
  logic [15:0] tanh_rom [TANH_ENTRIES];
  logic [15:0] tanh_q;
  logic tanh_neg;

  always_comb begin
    for (int k = 0; k < TANH_ENTRIES; k++) begin
      tanh_rom[k] = tanh_entry(k, TANH_ENTRIES);
    end
  end

  // Weight memories.
  logic fw_we, fb_we, l1w_we, l1b_we, l2w_we, l2b_we, ow_we, ob_we;
  logic [FW_A-1:0] fw_a;
  logic [FB_A-1:0] fb_a;
  logic [L1_A-1:0] l1w_a;
  logic [L2_A-1:0] l2w_a;
  logic [H_A-1:0] hb_a;
  logic [15:0] fw_q, fb_q, l1w_q, l1b_q, l2w_q, l2b_q, ow_q, ob_q;

  nae_mem #(.DEPTH(FW_D), .WIDTH(16)) u_fw (.clk, .we(fw_we), .addr(fw_a),
    .wdata(wval), .rdata(fw_q));
  nae_mem #(.DEPTH(ACCUM_DIM), .WIDTH(16)) u_fb (.clk, .we(fb_we), .addr(fb_a),
    .wdata(wval), .rdata(fb_q));
  nae_mem #(.DEPTH(L1_D), .WIDTH(16)) u_l1w (.clk, .we(l1w_we), .addr(l1w_a),
    .wdata(wval), .rdata(l1w_q));
  nae_mem #(.DEPTH(HIDDEN_DIM), .WIDTH(16)) u_l1b (.clk, .we(l1b_we), .addr(hb_a),
    .wdata(wval), .rdata(l1b_q));
  nae_mem #(.DEPTH(L2_D), .WIDTH(16)) u_l2w (.clk, .we(l2w_we), .addr(l2w_a),
    .wdata(wval), .rdata(l2w_q));
  nae_mem #(.DEPTH(HIDDEN_DIM), .WIDTH(16)) u_l2b (.clk, .we(l2b_we), .addr(hb_a),
    .wdata(wval), .rdata(l2b_q));
  nae_mem #(.DEPTH(HIDDEN_DIM), .WIDTH(16)) u_ow (.clk, .we(ow_we), .addr(hb_a),
    .wdata(wval), .rdata(ow_q));
  nae_mem #(.DEPTH(2), .WIDTH(16)) u_ob (.clk, .we(ob_we), .addr(1'b0),
    .wdata(wval), .rdata(ob_q));

  // Accumulator stack memory.
  logic sk_we;
  logic [SK_A-1:0] sk_a;
  logic [15:0] sk_wd, sk_q;
  nae_mem #(.DEPTH(SK_D), .WIDTH(16)) u_stack (.clk, .we(sk_we), .addr(sk_a),
    .wdata(sk_wd), .rdata(sk_q));

  logic wr_ok;
  logic [FB_A-1:0] el;
  assign el = ii[FB_A-1:0];

  always_comb begin
    case (region)
      RG_FW:   wr_ok = 32'(widx) < FW_D;
      RG_FB:   wr_ok = 32'(widx) < ACCUM_DIM;
      RG_L1W:  wr_ok = 32'(widx) < L1_D;
      RG_L2W:  wr_ok = 32'(widx) < L2_D;
      RG_L1B, RG_L2B, RG_OW: wr_ok = 32'(widx) < HIDDEN_DIM;
      default: wr_ok = widx == 17'd0;
    endcase
  end

  logic wr_go;
  assign wr_go = (state == S_ACC) && (op == OP_WRITE) && wr_ok;
  assign fw_we  = wr_go && region == RG_FW;
  assign fb_we  = wr_go && region == RG_FB;
  assign l1w_we = wr_go && region == RG_L1W;
  assign l1b_we = wr_go && region == RG_L1B;
  assign l2w_we = wr_go && region == RG_L2W;
  assign l2b_we = wr_go && region == RG_L2B;
  assign ow_we  = wr_go && region == RG_OW;
  assign ob_we  = wr_go && region == RG_OB;

  // Evaluation index: ii walks inputs, jj walks output neurons.
  logic [I_W-1:0] l1_in;
  logic in_half;
  assign in_half = ii >= I_W'(ACCUM_DIM);
  assign l1_in = ii;

  always_comb begin
    if (op == OP_WRITE) begin
      fw_a  = widx[FW_A-1:0];
      fb_a  = widx[FB_A-1:0];
      l1w_a = widx[L1_A-1:0];
      l2w_a = widx[L2_A-1:0];
      hb_a  = widx[H_A-1:0];
    end else begin
      fw_a  = FW_A'(32'(feat) * ACCUM_DIM + 32'(el));
      fb_a  = el;
      l1w_a = L1_A'(32'(l1_in) * HIDDEN_DIM + 32'(jj));
      l2w_a = L2_A'(32'(ii) * HIDDEN_DIM + 32'(jj));
      hb_a  = (state == S_L3) ? ii[H_A-1:0] : jj;
    end
  end

  // Stack port: reads in S_ACC/S_PUSH/S_L1, writes in the _W states.
  logic [SK_A-1:0] sk_base;
  logic [15:0] hold;
  logic [SK_A-1:0] wr_addr;
  assign sk_base = SK_A'((32'(sp) * 2 + 32'(side)) * ACCUM_DIM);
  always_comb begin
    sk_we = 1'b0;
    sk_wd = hold;
    sk_a  = SK_A'(32'(sk_base) + 32'(el));
    case (state)
      S_ACCW: begin
        sk_we = 1'b1;
        sk_a  = wr_addr;
      end
      S_PUSH: sk_a = SK_A'(32'(sp) * 2 * ACCUM_DIM + 32'(ii));
      S_PUSHW: begin
        sk_we = 1'b1;
        sk_wd = sk_q;
        sk_a  = SK_A'((32'(sp) + 1) * 2 * ACCUM_DIM + 32'(ii));
      end
      S_L1: sk_a = SK_A'(32'(sp) * 2 * ACCUM_DIM
                         + 32'(in_half ? !side : side) * ACCUM_DIM
                         + 32'(ii[FB_A-1:0]));
      default: ;
    endcase
  end

  assign in.ready = (state == S_IDLE);
  assign out.valid = (state == S_OUT);
  assign out.payload.status = status;
  assign out.payload.score = score;
  assign out.payload.stack_level = 6'(sp);

  logic signed [31:0] prod;
  logic signed [15:0] act;
  logic signed [15:0] wgt;
  logic signed [15:0] nar;
  logic [31:0] tidx;
  logic [16:0] amag;
  logic [H_A-1:0] prev_i;
  assign nar = narrow(sum);
  assign amag = nar[15] ? 17'(-$signed({nar[15], nar})) : 17'(nar);
  assign tidx = (32'(amag) * TANH_ENTRIES) >> 15;

  // The weight that arrives now was addressed in the previous cycle, at ii - 1.
  assign prev_i = ii[H_A-1:0] - H_A'(1);

  always_comb begin
    act = 16'sd0;
    wgt = 16'sd0;
    case (state)
      S_L1: begin
        act = clip_unit(sk_q);
        wgt = l1w_q;
      end
      S_L2: begin
        act = h1[prev_i];
        wgt = l2w_q;
      end
      S_L3: begin
        act = h2[prev_i];
        wgt = ow_q;
      end
      default: ;
    endcase
  end
  assign prod = act * wgt;

  // Multiply-accumulate loop: a read issued at ii arrives in the next cycle.
  logic [I_W-1:0] n_in;
  logic signed [15:0] bias_q;
  assign n_in = (state == S_L1) ? I_W'(2 * ACCUM_DIM) : I_W'(HIDDEN_DIM);
  assign bias_q = (state == S_L1) ? l1b_q : (state == S_L2) ? l2b_q : ob_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sp <= '0;
      rd_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in.valid) begin
          op     <= in.payload.op;
          region <= in.payload.region;
          widx   <= in.payload.weight_index;
          wval   <= in.payload.weight_value;
          feat   <= in.payload.feature_index;
          side   <= in.payload.side;
          ii     <= '0;
          jj     <= '0;
          status <= ST_OK;
          score  <= 16'sd0;
          state  <= S_ACC;
        end
        S_ACC: begin
          case (op)
            OP_WRITE: begin
              status <= wr_ok ? ST_OK : ST_RANGE;
              state <= S_OUT;
            end
            OP_RESET, OP_ADD: begin
              if (op == OP_ADD && 32'(feat) >= FEATURE_COUNT) begin
                status <= ST_RANGE;
                state <= S_OUT;
              end else begin
                wr_addr <= sk_a;
                state <= S_FIN;
              end
            end
            OP_PUSH: begin
              if (32'(sp) + 1 >= STACK_DEPTH) begin
                status <= ST_OVER;
                state <= S_OUT;
              end else begin
                state <= S_PUSH;
              end
            end
            OP_POP: begin
              if (sp == '0) begin
                status <= ST_UNDER;
              end else begin
                sp <= sp - 1'b1;
              end
              state <= S_OUT;
            end
            OP_EVAL: begin
              sum <= '0;
              rd_valid <= 1'b0;
              state <= S_L1;
            end
            default: begin
              status <= ST_RANGE;
              state <= S_OUT;
            end
          endcase
        end
        S_FIN: begin
          if (op == OP_RESET) begin
            hold <= fb_q;
          end else begin
            hold <= sat16(SUM_W'($signed(sk_q)) + SUM_W'($signed(fw_q)));
          end
          state <= S_ACCW;
        end
        S_ACCW: begin
          if (32'(ii) == ACCUM_DIM - 1) begin
            state <= S_OUT;
          end else begin
            ii <= ii + 1'b1;
            state <= S_ACC;
          end
        end
        S_PUSH: state <= S_PUSHW;
        S_PUSHW: begin
          if (32'(ii) == 2 * ACCUM_DIM - 1) begin
            sp <= sp + 1'b1;
            state <= S_OUT;
          end else begin
            ii <= ii + 1'b1;
            state <= S_PUSH;
          end
        end
        S_L1, S_L2, S_L3: begin
          if (rd_valid && rd_last) begin
            rd_valid <= 1'b0;
            rd_last <= 1'b0;
            ii <= '0;
            state <= S_DONE;
          end else begin
            rd_last <= (ii == n_in - 1'b1);
            rd_valid <= (ii < n_in);
            if (ii < n_in) begin
              ii <= ii + 1'b1;
            end
          end
          if (rd_valid) begin
            if (ii == I_W'(1)) begin
              sum <= (SUM_W'($signed(bias_q)) <<< 12) + SUM_W'(prod);
            end else begin
              sum <= sum + SUM_W'(prod);
            end
          end
        end
        S_DONE: begin
          ii <= '0;
          rd_valid <= 1'b0;
          case (region)
            RG_L1W: begin
              h1[jj] <= clip_unit(nar);
              if (32'(jj) == HIDDEN_DIM - 1) begin
                jj <= '0;
                region <= RG_L2W;
                state <= S_L2;
              end else begin
                jj <= jj + 1'b1;
                state <= S_L1;
              end
            end
            RG_L2W: begin
              h2[jj] <= clip_unit(nar);
              if (32'(jj) == HIDDEN_DIM - 1) begin
                jj <= '0;
                region <= RG_OW;
                state <= S_L3;
              end else begin
                jj <= jj + 1'b1;
                state <= S_L2;
              end
            end
            default: begin
              tanh_q <= tanh_rom[(tidx >= 32'(TANH_ENTRIES)) ? T_A'(TANH_ENTRIES - 1)
                                                              : tidx[T_A-1:0]];
              tanh_neg <= nar[15];
              state <= S_TANH;
            end
          endcase
        end
        S_TANH: begin
          score <= tanh_neg ? -$signed(tanh_q) : $signed(tanh_q);
          state <= S_OUT;
        end
        S_OUT: if (out.ready) begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_ACC && op == OP_EVAL) begin
        region <= RG_L1W;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |=> out.valid && $stable(out.payload.score))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (rst)
    in.ready |-> !out.valid)
    else $error("input taken while result pending");
  assert property (@(posedge clk) disable iff (rst)
    32'(sp) < STACK_DEPTH)
    else $error("stack pointer out of range");
  assert property (@(posedge clk) disable iff (rst)
    out.valid && out.payload.status != ST_OK |-> out.payload.score == 16'sd0)
    else $error("score on refused transaction");
endmodule

[test/tb_nnue_accumulator_evaluator.sv]
// Self-checking regression of the NNUE accumulator evaluator with a built-in network predictor.
`timescale 1ns / 100ps

module tb_nnue_accumulator_evaluator;
  import nae_pkg::*;

  localparam int ACC_N    = 128;
  localparam int HID_N    = 32;
  localparam int FEAT_N   = 649;
  localparam int LEVELS   = 64;
  localparam int LUT_N    = 1024;
  localparam int LIMIT    = 4000000;

  logic clk;
  logic rst;

  nae_if #(.PAYLOAD_T(in_item_t))  in_ch (clk);
  nae_if #(.PAYLOAD_T(out_item_t)) out_ch (clk);

  nnue_accumulator_evaluator i_dut (
    .clk (clk),
    .rst (rst),
    .in  (in_ch),
    .out (out_ch)
  );

  shortint   feat_w [FEAT_N*ACC_N];
  shortint   feat_b [ACC_N];
  shortint   l1_w [2*ACC_N*HID_N];
  shortint   l1_b [HID_N];
  shortint   l2_w [HID_N*HID_N];
  shortint   l2_b [HID_N];
  shortint   out_w [HID_N];
  shortint   out_b;
  shortint   acc_mem [LEVELS][2][ACC_N];
  bit        level_live [LEVELS][2];
  int        sp;
  shortint   tanh_lut [LUT_N];
  int        loaded_rows[$];
  out_item_t expected_q[$];

  int  errors;
  int  cycles;
  bit  steady;
  int  burst_left;
  int  hold_left;
  int  pat_left;
  int  stall_pct;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("nnue_accumulator_evaluator regression: fail");
      $finish;
    end
  end

  function automatic shortint clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return shortint'(v);
  endfunction

  function automatic shortint unit_clip(shortint v);
    if (v <= 0) return 0;
    if (v >= 4096) return 4096;
    return v;
  endfunction

  function automatic shortint to_q12(longint s);
    longint v;
    v = (s + 2048) >>> 12;
    return clamp16(v);
  endfunction

  function automatic void build_tanh_lut();
    bit [63:0] one, t, t2, t3, t4, v, num, den;
    one = 64'd1 << 31;
    for (int i = 0; i < LUT_N; i++) begin
      t = (64'(i) << 31) / (64'd16 * 64'(LUT_N));
      t2 = (t * t) >> 31;
      t3 = (t2 * t) >> 31;
      t4 = (t3 * t) >> 31;
      v = one - t + t2 / 2 - t3 / 6 + t4 / 24;
      for (int k = 0; k < 8; k++) v = (v * v) >> 31;
      num = (one - v) * 64'd32768 + (one + v);
      den = 64'd2 * (one + v);
      tanh_lut[i] = shortint'(num / den);
    end
  endfunction

  function automatic int store_words(logic [2:0] rg);
    case (rg)
      RG_FW:   return FEAT_N * ACC_N;
      RG_FB:   return ACC_N;
      RG_L1W:  return 2 * ACC_N * HID_N;
      RG_L1B:  return HID_N;
      RG_L2W:  return HID_N * HID_N;
      RG_L2B:  return HID_N;
      RG_OW:   return HID_N;
      default: return 1;
    endcase
  endfunction

  function automatic shortint network_score(bit stm);
    shortint cat [2*ACC_N];
    shortint h1 [HID_N];
    shortint h2 [HID_N];
    longint  s;
    shortint x, r;
    int      a, idx;
    for (int i = 0; i < ACC_N; i++) begin
      cat[i] = unit_clip(acc_mem[sp][stm][i]);
      cat[ACC_N+i] = unit_clip(acc_mem[sp][!stm][i]);
    end
    for (int j = 0; j < HID_N; j++) begin
      s = longint'(l1_b[j]) * 4096;
      for (int i = 0; i < 2*ACC_N; i++) s += longint'(cat[i]) * l1_w[i*HID_N+j];
      h1[j] = unit_clip(to_q12(s));
    end
    for (int j = 0; j < HID_N; j++) begin
      s = longint'(l2_b[j]) * 4096;
      for (int i = 0; i < HID_N; i++) s += longint'(h1[i]) * l2_w[i*HID_N+j];
      h2[j] = unit_clip(to_q12(s));
    end
    s = longint'(out_b) * 4096;
    for (int i = 0; i < HID_N; i++) s += longint'(h2[i]) * out_w[i];
    x = to_q12(s);
    a = (x < 0) ? -int'(x) : int'(x);
    idx = (a * LUT_N) >> 15;
    if (idx >= LUT_N) idx = LUT_N - 1;
    r = tanh_lut[idx];
    return (x < 0) ? -r : r;
  endfunction

  function automatic out_item_t apply_item(in_item_t it);
    out_item_t r;
    int        idx;
    shortint   val;
    r = '0;
    r.status = ST_OK;
    idx = int'(it.weight_index);
    val = shortint'(it.weight_value);
    case (it.op)
      OP_WRITE: begin
        if (idx >= store_words(it.region)) begin
          r.status = ST_RANGE;
        end else begin
          case (it.region)
            RG_FW:   feat_w[idx] = val;
            RG_FB:   feat_b[idx] = val;
            RG_L1W:  l1_w[idx] = val;
            RG_L1B:  l1_b[idx] = val;
            RG_L2W:  l2_w[idx] = val;
            RG_L2B:  l2_b[idx] = val;
            RG_OW:   out_w[idx] = val;
            default: out_b = val;
          endcase
        end
      end
      OP_RESET: begin
        for (int j = 0; j < ACC_N; j++) acc_mem[sp][it.side][j] = feat_b[j];
        level_live[sp][it.side] = 1'b1;
      end
      OP_ADD: begin
        if (int'(it.feature_index) >= FEAT_N) begin
          r.status = ST_RANGE;
        end else begin
          for (int j = 0; j < ACC_N; j++) begin
            acc_mem[sp][it.side][j] = clamp16(longint'(acc_mem[sp][it.side][j]) +
                feat_w[int'(it.feature_index)*ACC_N+j]);
          end
        end
      end
      OP_PUSH: begin
        if (sp + 1 >= LEVELS) begin
          r.status = ST_OVER;
        end else begin
          acc_mem[sp+1] = acc_mem[sp];
          level_live[sp+1] = level_live[sp];
          sp++;
        end
      end
      OP_POP: begin
        if (sp == 0) r.status = ST_UNDER;
        else sp--;
      end
      OP_EVAL: r.score = network_score(it.side);
      default: r.status = ST_RANGE;
    endcase
    r.stack_level = sp[5:0];
    return r;
  endfunction

  // Drives one transaction from a falling edge and returns at a falling edge.
  task automatic send_item(in_item_t it);
    int gap;
    if (!steady) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 12);
        repeat (gap) @(negedge clk);
        burst_left = $urandom_range(1, 20);
      end
      burst_left--;
    end
    in_ch.payload = it;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    expected_q.push_back(apply_item(it));
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic in_item_t blank_item(logic [2:0] op);
    in_item_t it;
    it.op = op;
    it.region = 3'($urandom);
    it.weight_index = 17'($urandom);
    it.weight_value = 16'($urandom);
    it.feature_index = 10'($urandom);
    it.side = 1'($urandom);
    return it;
  endfunction

  function automatic logic [15:0] rand_weight();
    if ($urandom_range(0, 99) < 80) return 16'($urandom_range(0, 1200) - 600);
    return 16'($urandom);
  endfunction

  task automatic write_word(logic [2:0] rg, int idx, logic [15:0] val);
    in_item_t it;
    it = blank_item(OP_WRITE);
    it.region = rg;
    it.weight_index = 17'(idx);
    it.weight_value = val;
    send_item(it);
  endtask

  task automatic simple_op(logic [2:0] op, logic side, int feat);
    in_item_t it;
    it = blank_item(op);
    it.side = side;
    it.feature_index = 10'(feat);
    send_item(it);
  endtask

  task automatic load_row(int row, bit extreme);
    for (int j = 0; j < ACC_N; j++) begin
      if (extreme) write_word(RG_FW, row*ACC_N+j, (j % 2) ? 16'h8000 : 16'h7fff);
      else write_word(RG_FW, row*ACC_N+j, rand_weight());
    end
    loaded_rows.push_back(row);
  endtask

  task automatic test_load_network();
    int row;
    steady = 1'b1;
    for (int rg = 1; rg < 8; rg++) begin
      for (int i = 0; i < store_words(3'(rg)); i++) write_word(3'(rg), i, rand_weight());
    end
    load_row(0, 1'b0);
    load_row(FEAT_N-1, 1'b1);
    for (int n = 0; n < 6; n++) begin
      row = $urandom_range(1, FEAT_N-2);
      load_row(row, 1'b0);
    end
    steady = 1'b0;
    wait_drained();
  endtask

  task automatic test_weight_range();
    write_word(RG_OB, 0, 16'h7fff);
    write_word(RG_OW, HID_N-1, 16'h8000);
    write_word(RG_FW, FEAT_N*ACC_N, 16'h1234);
    write_word(RG_FB, ACC_N, 16'h1234);
    write_word(RG_L1W, 2*ACC_N*HID_N, 16'h1234);
    write_word(RG_OB, 1, 16'h1234);
    write_word(RG_L2B, 17'h1ffff, 16'hffff);
    simple_op(3'd6, 1'b0, 0);
    simple_op(3'd7, 1'b1, 0);
    wait_drained();
  endtask

  task automatic test_accumulators();
    simple_op(OP_RESET, 1'b0, 0);
    simple_op(OP_RESET, 1'b1, 0);
    simple_op(OP_ADD, 1'b0, 0);
    simple_op(OP_ADD, 1'b1, FEAT_N-1);
    simple_op(OP_ADD, 1'b1, FEAT_N-1);
    simple_op(OP_ADD, 1'b0, FEAT_N);
    simple_op(OP_ADD, 1'b1, 1023);
    simple_op(OP_EVAL, 1'b0, 0);
    simple_op(OP_EVAL, 1'b1, 0);
    wait_drained();
  endtask

  task automatic test_stack_limits();
    simple_op(OP_POP, 1'b0, 0);
    simple_op(OP_POP, 1'b0, 0);
    while (sp < LEVELS-1) simple_op(OP_PUSH, 1'b0, 0);
    simple_op(OP_PUSH, 1'b1, 0);
    simple_op(OP_EVAL, 1'b1, 0);
    while (sp > 0) simple_op(OP_POP, 1'b1, 0);
    simple_op(OP_POP, 1'b0, 0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_left = 600;
    for (int n = 0; n < 6; n++) simple_op(OP_ADD, 1'($urandom), loaded_rows[0]);
    wait_drained();
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    int       r, size;
    r = $urandom_range(0, 99);
    it = blank_item(OP_RESET);
    if (r < 30) begin
      it.op = OP_WRITE;
      it.weight_value = rand_weight();
      size = store_words(it.region);
      if ($urandom_range(0, 99) < 8) begin
        it.weight_index = 17'($urandom_range(size, 131071));
      end else if (it.region == RG_FW) begin
        it.weight_index = 17'(loaded_rows[$urandom_range(0, loaded_rows.size()-1)] * ACC_N +
            $urandom_range(0, ACC_N-1));
      end else begin
        it.weight_index = 17'($urandom_range(0, size-1));
      end
    end else if (r < 40) begin
      it.op = OP_RESET;
    end else if (r < 65) begin
      if (level_live[sp][it.side]) begin
        it.op = OP_ADD;
        if ($urandom_range(0, 99) < 6) it.feature_index = 10'($urandom_range(FEAT_N, 1023));
        else it.feature_index = 10'(loaded_rows[$urandom_range(0, loaded_rows.size()-1)]);
      end
    end else if (r < 77) begin
      if (level_live[sp][0] && level_live[sp][1]) it.op = OP_PUSH;
    end else if (r < 89) begin
      it.op = OP_POP;
    end else if (r < 95) begin
      if (level_live[sp][0] && level_live[sp][1]) it.op = OP_EVAL;
    end else begin
      it.op = 3'($urandom_range(6, 7));
    end
    return it;
  endfunction

  task automatic test_random();
    for (int n = 0; n < 950; n++) begin
      send_item(random_item());
      if (n == 475) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        if (pat_left == 0) begin
          case ($urandom_range(0, 4))
            0, 1:    stall_pct = 0;
            2:       stall_pct = 25;
            3:       stall_pct = 60;
            default: stall_pct = 90;
          endcase
          pat_left = $urandom_range(10, 200);
        end
        pat_left--;
        out_ch.ready = ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result status %0d score %0d level %0d", $time,
            out_ch.payload.status, $signed(out_ch.payload.score), out_ch.payload.stack_level);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (out_ch.payload.status !== want.status) begin
          $display("%0t status expected %0d actual %0d", $time, want.status,
              out_ch.payload.status);
          errors++;
        end
        if (out_ch.payload.score !== want.score) begin
          $display("%0t score expected %0d actual %0d", $time, $signed(want.score),
              $signed(out_ch.payload.score));
          errors++;
        end
        if (out_ch.payload.stack_level !== want.stack_level) begin
          $display("%0t stack_level expected %0d actual %0d", $time, want.stack_level,
              out_ch.payload.stack_level);
          errors++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    errors = 0;
    cycles = 0;
    steady = 1'b0;
    burst_left = 0;
    hold_left = 0;
    pat_left = 0;
    stall_pct = 0;
    sp = 0;
    out_b = 0;
    build_tanh_lut();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_load_network();
    test_weight_range();
    test_accumulators();
    test_stack_limits();
    test_backpressure();
    test_random();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("nnue_accumulator_evaluator regression: pass");
    end else begin
      $display("nnue_accumulator_evaluator regression: fail");
    end
    $finish;
  end

endmodule
